[hdl/md4hrs_pkg.sv]
// Shared types, constants and step tables for the reduced-step MD4 core.
package md4hrs_pkg;

  // Chaining word initial values
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // Round additive constants
  localparam logic [31:0] K_ROUND1 = 32'h5a827999;
  localparam logic [31:0] K_ROUND2 = 32'h6ed9eba1;

  localparam logic [5:0] STEPS_MAX = 6'd48;
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] POS_LAST  = 6'd63;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD1,
    S_PAD2,
    S_LOAD,
    S_STEP,
    S_ADD,
    S_OUT
  } state_t;

  // What the current compression belongs to
  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD1,
    PH_FINAL
  } phase_t;

  typedef struct packed {
    logic absorb;
    logic pad_first;
    logic pad_second;
    logic load;
    logic step;
    logic add;
    logic out_adv;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pad_two;
    logic limit_zero;
    logic step_last;
    logic out_last;
  } status_t;

  // Message word index used by step i
  function automatic logic [3:0] word_sel(input logic [5:0] i);
    logic [3:0] sel;
    case (i[5:4])
      2'd0:    sel = i[3:0];
      2'd1:    sel = {i[1:0], i[3:2]};
      default: sel = {i[0], i[1], i[2], i[3]};
    endcase
    return sel;
  endfunction

  // Rotate amount for a round and step position within a group of four
  function automatic logic [4:0] rot_amt(input logic [1:0] rnd, input logic [1:0] j);
    logic [4:0] s;
    case (rnd)
      2'd0: begin
        case (j)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd7;
          2'd2:    s = 5'd11;
          default: s = 5'd19;
        endcase
      end
      2'd1: begin
        case (j)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd5;
          2'd2:    s = 5'd9;
          default: s = 5'd13;
        endcase
      end
      default: begin
        case (j)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd9;
          2'd2:    s = 5'd11;
          default: s = 5'd15;
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

endpackage

[hdl/md4_hash_reduced_steps_core.sv]
// MD4 digest over a byte stream with a programmable number of compression
// steps (cfg_wr_data, 0 to 48; larger values run all 48; reset value 48).
// One input word is taken per cycle while bytes fill the 64-byte block.
// The word that completes a block, and every word with message_end set,
// holds off the input while the single shared step unit runs: one step per
// cycle, N steps rounded up to a group of four, between a load and an add.
// Message end adds a padding state, a second padded block when 56 or more
// bytes sit in the last block, and then four digest words a, b, c, d on the
// output channel, last_word marking d. After d is taken the chaining words
// and byte count return to their initial values. The user must change the
// step count only while the core is idle; the core does not enforce this.
module md4_hash_reduced_steps_core
  import md4hrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic        last_word,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data
);

  cmd_t    cmd;
  status_t status;

  md4hrs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_present (byte_present),
    .message_end  (message_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .cmd          (cmd)
  );

  md4hrs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .data_byte   (data_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .digest_word (digest_word),
    .last_word   (last_word)
  );

  // Input and output sides are never open at once
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready while digest word pending");

  // Taking the final digest word returns the core to idle
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_word |=> in_ready && !out_valid)
    else $error("core not idle after final digest word");

  // A message end always starts the finishing sequence
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && message_end |=> !in_ready)
    else $error("message end did not leave idle");

  // Digest words only come out of a finished message: first word is a
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !last_word)
    else $error("digest output did not start at word a");

endmodule

[hdl/md4hrs_dp.sv]
// Datapath: block buffer, byte counter, chaining words and the step unit.
module md4hrs_dp
  import md4hrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [7:0]  data_byte,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,
  output logic [31:0] digest_word,
  output logic        last_word
);

  logic [31:0] chain [4];
  logic [31:0] words [16];
  logic [60:0] byte_total;
  logic [5:0]  step_count;
  logic [5:0]  cnt;
  logic [1:0]  oidx;
  // Working words; slot a is the one updated each step, slots rotate on each step
  logic [31:0] wa, wb, wc, wd;

  logic [5:0]  used;
  logic [5:0]  limit;
  logic [63:0] bit_len;
  logic [1:0]  rnd;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] m_val;
  logic [31:0] sum;
  logic [31:0] wa_in;

  assign used    = byte_total[5:0];
  assign bit_len = {byte_total, 3'b000};
  assign limit   = (step_count > STEPS_MAX) ? STEPS_MAX : step_count;
  assign rnd     = cnt[5:4];

  // Round function and constant
  always_comb begin
    case (rnd)
      2'd0: begin
        f_val = wd ^ (wb & (wc ^ wd));
        k_val = '0;
      end
      2'd1: begin
        f_val = (wb & (wc | wd)) | (wc & wd);
        k_val = K_ROUND1;
      end
      default: begin
        f_val = wb ^ wc ^ wd;
        k_val = K_ROUND2;
      end
    endcase
  end

  assign m_val = words[word_sel(cnt)];
  assign sum   = wa + f_val + m_val + k_val;
  // Past the limit the slots only rotate, to realign on a group of four
  assign wa_in = (cnt < limit) ? rotl(sum, rot_amt(rnd, cnt[1:0])) : wa;

  // Status to the controller
  assign status.pos_last   = (used == POS_LAST);
  assign status.pad_two    = (used >= LEN_START);
  assign status.limit_zero = (limit == '0);
  assign status.step_last  = (cnt[1:0] == 2'd3) && ((cnt + 6'd1) >= limit);
  assign status.out_last   = (oidx == 2'd3);

  assign digest_word = chain[oidx];
  assign last_word   = (oidx == 2'd3);

  // Control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= STEPS_MAX;
      byte_total <= '0;
      oidx       <= '0;
      chain[0]   <= IV_A;
      chain[1]   <= IV_B;
      chain[2]   <= IV_C;
      chain[3]   <= IV_D;
    end else begin
      if (cfg_wr_en) begin
        step_count <= cfg_wr_data;
      end
      if (cmd.absorb) begin
        byte_total <= byte_total + 61'd1;
      end
      if (cmd.add) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
      end
      if (cmd.out_adv) begin
        oidx <= oidx + 2'd1;
      end
      if (cmd.clear) begin
        byte_total <= '0;
        chain[0]   <= IV_A;
        chain[1]   <= IV_B;
        chain[2]   <= IV_C;
        chain[3]   <= IV_D;
      end
    end
  end

  // Step unit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wa  <= chain[0];
      wb  <= chain[1];
      wc  <= chain[2];
      wd  <= chain[3];
      cnt <= '0;
    end else if (cmd.step) begin
      wa  <= wd;
      wb  <= wa_in;
      wc  <= wb;
      wd  <= wc;
      cnt <= cnt + 6'd1;
    end
  end

  // Block buffer: byte writes, padding and length
  always_ff @(posedge clk) begin
    if (cmd.absorb) begin
      words[used[5:2]][{used[1:0], 3'b000} +: 8] <= data_byte;
    end
    if (cmd.pad_first) begin
      for (int w = 0; w < 16; w++) begin
        for (int b = 0; b < 4; b++) begin
          if ((w >= 14) && (used < LEN_START)) begin
            // Length fits behind the pad byte in this block
            words[w][8*b +: 8] <= bit_len[32*(w % 2) + 8*b +: 8];
          end else if (6'(4 * w + b) == used) begin
            words[w][8*b +: 8] <= PAD_BYTE;
          end else if (6'(4 * w + b) > used) begin
            words[w][8*b +: 8] <= '0;
          end
        end
      end
    end
    if (cmd.pad_second) begin
      for (int w = 0; w < 14; w++) begin
        words[w] <= '0;
      end
      words[14] <= bit_len[31:0];
      words[15] <= bit_len[63:32];
    end
  end

endmodule

[hdl/md4hrs_ctrl.sv]
// Controller: sequences byte intake, padding, compression and digest output.
module md4hrs_ctrl
  import md4hrs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    byte_present,
  input  logic    message_end,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   pend, pend_next;
  logic   fire;

  assign fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_DATA;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      pend  <= pend_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    pend_next  = pend;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.absorb = fire && byte_present;
        if (fire) begin
          if (byte_present && status.pos_last) begin
            // Block full: compress, then finish if this word ends the message
            state_next = S_LOAD;
            phase_next = PH_DATA;
            pend_next  = message_end;
          end else if (message_end) begin
            state_next = S_PAD1;
          end
        end
      end
      S_PAD1: begin
        cmd.pad_first = 1'b1;
        phase_next    = status.pad_two ? PH_PAD1 : PH_FINAL;
        state_next    = S_LOAD;
      end
      S_PAD2: begin
        cmd.pad_second = 1'b1;
        phase_next     = PH_FINAL;
        state_next     = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = status.limit_zero ? S_ADD : S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (status.step_last) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add = 1'b1;
        case (phase)
          PH_DATA: begin
            state_next = pend ? S_PAD1 : S_IDLE;
            pend_next  = 1'b0;
          end
          PH_PAD1: state_next = S_PAD2;
          default: state_next = S_OUT;
        endcase
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.out_adv = 1'b1;
          if (status.out_last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[dv/tb.sv]
module tb;
  import md4hrs_pkg::IV_A;
  import md4hrs_pkg::IV_B;
  import md4hrs_pkg::IV_C;
  import md4hrs_pkg::IV_D;
  import md4hrs_pkg::K_ROUND1;
  import md4hrs_pkg::K_ROUND2;
  import md4hrs_pkg::STEPS_MAX;
  import md4hrs_pkg::PAD_BYTE;

  localparam int SETTLE_CYCLES = 120;   // worst block pair plus padding, with margin
  localparam int IDLE_LIMIT    = 4000;  // cycles with no word moving on either side

  typedef struct {
    logic [31:0] word;
    logic        last;
  } digest_exp_t;

  typedef enum logic [1:0] {
    RDY_OPEN,
    RDY_RANDOM,
    RDY_PATTERN
  } rdy_mode_t;

  // DUT I/O
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        message_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic        last_word;
  logic        cfg_wr_en = 1'b0;
  logic [5:0]  cfg_wr_data = 6'd0;

  // MD4 step tables: message word per step, rotate per round/position, target word
  int msg_idx [48] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
                       0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15,
                       0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15};
  int rot_tab [12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};
  int dst_tab [4]  = '{0, 3, 2, 1};

  // Predictor state
  logic [31:0] digest_chain [4];
  logic [7:0]  block_buf [64];
  logic [60:0] msg_len;
  logic [5:0]  step_limit;
  digest_exp_t digest_q [$];

  // Bookkeeping
  int errors = 0;
  int words_sent = 0;
  int messages = 0;
  int settings_used = 0;
  int digests_checked = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  rdy_mode_t rdy_mode = RDY_OPEN;
  int rdy_span = 0;
  int rdy_tick = 0;

  md4_hash_reduced_steps_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .message_end  (message_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digest_word  (digest_word),
    .last_word    (last_word),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] rol32(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void load_iv();
    digest_chain[0] = IV_A;
    digest_chain[1] = IV_B;
    digest_chain[2] = IV_C;
    digest_chain[3] = IV_D;
    msg_len = '0;
  endfunction

  // One compression over block_buf, cut short after step_limit steps
  function automatic void mix_block();
    logic [31:0] v [4];
    logic [31:0] m [16];
    logic [31:0] x, y, z, f, kc;
    int i, lim, rnd, t;
    for (i = 0; i < 16; i++)
      m[i] = {block_buf[4*i+3], block_buf[4*i+2], block_buf[4*i+1], block_buf[4*i]};
    for (i = 0; i < 4; i++)
      v[i] = digest_chain[i];
    lim = (step_limit > STEPS_MAX) ? int'(STEPS_MAX) : int'(step_limit);
    for (i = 0; i < lim; i++) begin
      rnd = i / 16;
      t = dst_tab[i % 4];
      x = v[(t + 1) % 4];
      y = v[(t + 2) % 4];
      z = v[(t + 3) % 4];
      if (rnd == 0) begin
        f = z ^ (x & (y ^ z));
        kc = 32'h0;
      end else if (rnd == 1) begin
        f = (x & (y | z)) | (y & z);
        kc = K_ROUND1;
      end else begin
        f = x ^ y ^ z;
        kc = K_ROUND2;
      end
      v[t] = rol32(v[t] + f + m[msg_idx[i]] + kc, rot_tab[rnd * 4 + (i % 4)]);
    end
    // feed-forward is always applied, even with zero steps
    for (i = 0; i < 4; i++)
      digest_chain[i] = digest_chain[i] + v[i];
  endfunction

  // Pad, append bit length, compress once or twice
  function automatic void close_message();
    int used, i;
    logic [63:0] bit_len;
    used = int'(msg_len[5:0]);
    bit_len = {msg_len, 3'b000};
    block_buf[used] = PAD_BYTE;
    used++;
    if (used > 56) begin
      for (i = used; i < 64; i++)
        block_buf[i] = 8'h00;
      mix_block();
      used = 0;
    end
    for (i = used; i < 56; i++)
      block_buf[i] = 8'h00;
    for (i = 0; i < 8; i++)
      block_buf[56 + i] = bit_len[8*i +: 8];
    mix_block();
  endfunction

  // Update the model for one accepted input word
  function automatic void absorb_word(input logic [7:0] b, input logic p, input logic e);
    digest_exp_t ex;
    int pos, i;
    if (p) begin
      pos = int'(msg_len[5:0]);
      block_buf[pos] = b;
      msg_len = msg_len + 61'd1;
      if (pos == 63)
        mix_block();
    end
    if (e) begin
      close_message();
      for (i = 0; i < 4; i++) begin
        ex.word = digest_chain[i];
        ex.last = (i == 3);
        digest_q.push_back(ex);
      end
      load_iv();
    end
  endfunction

  // ---------------------------------------------------------------- output side

  // Receiver backpressure: open, random, or a fixed 3-of-7 stall pattern
  always @(negedge clk) begin
    if (rdy_span == 0) begin
      rdy_mode <= rdy_mode_t'($urandom_range(0, 2));
      rdy_span <= $urandom_range(16, 160);
    end else begin
      rdy_span <= rdy_span - 1;
    end
    rdy_tick <= rdy_tick + 1;
    case (rdy_mode)
      RDY_OPEN:   out_ready <= 1'b1;
      RDY_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
      default:    out_ready <= ((rdy_tick % 7) >= 3);
    endcase
  end

  // Digest checker
  always @(posedge clk) begin
    digest_exp_t ex;
    if (!rst && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word: got %h last %b, nothing pending",
                 $time, digest_word, last_word);
        errors++;
      end else begin
        ex = digest_q.pop_front();
        digests_checked++;
        if (digest_word !== ex.word) begin
          $display("%0t: digest word mismatch: expected %h, got %h",
                   $time, ex.word, digest_word);
          errors++;
        end
        if (last_word !== ex.last) begin
          $display("%0t: last_word mismatch: expected %b, got %b",
                   $time, ex.last, last_word);
          errors++;
        end
      end
    end
  end

  // Watchdog on stalled traffic
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d digest words pending",
               $time, IDLE_LIMIT, digest_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- input side

  // Send one word; bursts of random length separated by random gaps
  task automatic send_word(input logic [7:0] b, input logic p, input logic e);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    data_byte    <= b;
    byte_present <= p;
    message_end  <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_word(b, p, e);
    words_sent++;
  endtask

  // Drop valid and hold until every pending digest word is out
  task automatic wait_for_digests();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // Fully idle: drained and given time to finish any trailing compression
  task automatic quiesce();
    wait_for_digests();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_steps(input logic [5:0] n);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    step_limit = n;
    settings_used++;
  endtask

  // Random message of len bytes, ending on the last byte or on an empty word;
  // occasional empty non-end words are mixed in as noise
  task automatic send_message(input int len, output int sent);
    logic end_on_byte;
    int i;
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    sent = 0;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0)
        send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
      sent++;
    end
    if (!end_on_byte) begin
      send_word(8'($urandom), 1'b0, 1'b1);
      sent++;
    end
    messages++;
  endtask

  // Lengths favor short messages and the one/two padding block boundary
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65)
      return $urandom_range(0, 20);
    else if (r < 90)
      return $urandom_range(52, 66);
    else if (r < 97)
      return $urandom_range(100, 140);
    else
      return ($urandom_range(0, 1) == 1) ? 64 : 128;
  endfunction

  // ---------------------------------------------------------------- tests

  // Reset step count (48): empty message, then single byte with end
  task automatic test_reset_steps();
    send_word(8'($urandom), 1'b0, 1'b1);
    send_word(8'h61, 1'b1, 1'b1);
    messages += 2;
  endtask

  // Empty non-end words must be ignored mid-message
  task automatic test_empty_words();
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h5a, 1'b0, 1'b0);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'ha5, 1'b0, 1'b0);
    send_word(8'h3c, 1'b0, 1'b1);
    messages++;
  endtask

  // Byte extremes and all-bit patterns, last byte carries the end flag
  task automatic test_byte_extremes();
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'h55, 1'b1, 1'b0);
    send_word(8'haa, 1'b1, 1'b0);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'h7f, 1'b1, 1'b0);
    send_word(8'hfe, 1'b1, 1'b1);
    messages++;
  endtask

  // Zero steps (pure doubling) and a saturating count above 48
  task automatic test_step_extremes();
    quiesce();
    set_steps(6'd0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'h12, 1'b1, 1'b1);
    quiesce();
    set_steps(6'd63);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b1);
    messages += 3;
  endtask

  // Random messages over a sweep of step counts
  task automatic test_random_messages();
    logic [5:0] sweep [$];
    int per_setting, sent;
    sweep = '{6'd1, 6'd49, 6'd0, 6'd5, 6'd16, 6'd31, 6'd47, 6'd63, 6'd48};
    sweep.push_back(6'($urandom_range(0, 63)));
    foreach (sweep[idx]) begin
      quiesce();
      set_steps(sweep[idx]);
      per_setting = 0;
      while (per_setting < 8) begin
        send_message(pick_length(), sent);
        per_setting += sent;
        if ($urandom_range(0, 3) == 0)
          wait_for_digests();
      end
    end
  endtask

  initial begin
    step_limit = STEPS_MAX;
    load_iv();
    foreach (block_buf[i]) block_buf[i] = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_steps();
    test_empty_words();
    test_byte_extremes();
    test_step_extremes();
    test_random_messages();

    quiesce();
    $display("Sent %0d input words in %0d messages across %0d step-count writes (0..63).",
             words_sent, messages, settings_used);
    $display("Checked %0d digest words with random input gaps and output stalls.",
             digests_checked);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[md4_hash_reduced_steps_core.f]
hdl/md4hrs_pkg.sv
hdl/md4hrs_dp.sv
hdl/md4hrs_ctrl.sv
hdl/md4_hash_reduced_steps_core.sv
dv/tb.sv
